FILE: src/vfc_pkg.sv
// ----------------------------------------------------------------------------
// vfc_pkg: shared types and constants of the valid-mode FIR convolver
// Sizes of the tap chain, the product and sum words, and the register map.
// ----------------------------------------------------------------------------
package vfc_pkg;

  localparam int MAX_TAPS    = 16;
  localparam int SAMPLE_BITS = 16;

  localparam int SAMPLE_W    = 16;
  localparam int COEF_W      = 16;
  localparam int PROD_W      = SAMPLE_W + COEF_W;
  localparam int CONV_W      = 36;

  localparam int COEF_WORDS  = 4;
  localparam int CFG_W       = 64;
  localparam int CFG_IDX_W   = 3;
  localparam int TAP_CNT_W   = 5;

  localparam int TAP_W       = $clog2(MAX_TAPS + 1);
  localparam int TAP_IDX_W   = $clog2(MAX_TAPS);
  localparam int TREE_LEVELS = $clog2(MAX_TAPS);
  localparam int TREE_LEAVES = 1 << TREE_LEVELS;

  // register map
  localparam logic [CFG_IDX_W-1:0] REG_COEF_0    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_1    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_2    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_3    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT = 3'd4;

  // status that travels alongside one result through the pipeline
  typedef struct packed {
    logic valid;
    logic last;
    logic too_short;
  } vfc_tag_t;

endpackage

FILE: src/vfc_cell.sv
// ----------------------------------------------------------------------------
// vfc_cell: one tap of the sample chain
// Holds one window sample, hands it to the next cell on each transfer, and
// registers its weighted product.
// ----------------------------------------------------------------------------
module vfc_cell
  import vfc_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       shift_i,
  input  logic                       advance_i,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  input  logic signed [COEF_W-1:0]   coef_i,
  input  logic                       tap_en_i,
  output logic signed [SAMPLE_W-1:0] sample_o,
  output logic signed [PROD_W-1:0]   product_o
);

  logic signed [SAMPLE_W-1:0] sample_q;
  logic signed [PROD_W-1:0]   product_d;
  logic signed [PROD_W-1:0]   product_q;

  // taps beyond the kernel length contribute nothing
  always_comb begin
    if (tap_en_i) begin
      product_d = sample_q * coef_i;
    end else begin
      product_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      sample_q <= sample_i;
    end
    if (advance_i) begin
      product_q <= product_d;
    end
  end

  assign sample_o  = sample_q;
  assign product_o = product_q;

endmodule

FILE: src/vfc_add_tree.sv
// ----------------------------------------------------------------------------
// vfc_add_tree: registered pairwise adder tree
// Sums the cell products with every tree level registered, with the result tag
// carried in step.
// ----------------------------------------------------------------------------
module vfc_add_tree
  import vfc_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     advance_i,
  input  logic signed [PROD_W-1:0] leaf_i [MAX_TAPS],
  input  vfc_tag_t                 tag_i,
  output logic signed [CONV_W-1:0] sum_o,
  output vfc_tag_t                 tag_o
);

  logic signed [CONV_W-1:0] node     [2*TREE_LEAVES];
  logic signed [CONV_W-1:0] sum_d    [1:TREE_LEAVES-1];
  logic signed [CONV_W-1:0] sum_q    [1:TREE_LEAVES-1];
  vfc_tag_t                 tag_q    [TREE_LEVELS];

  // heap order: node n has children 2n and 2n+1, leaves start at index TREE_LEAVES
  always_comb begin
    node[0] = '0;
    for (int n = 1; n < TREE_LEAVES; n++) begin
      node[n] = sum_q[n];
    end
    for (int i = 0; i < TREE_LEAVES; i++) begin
      if (i < MAX_TAPS) begin
        node[TREE_LEAVES + i] = {{(CONV_W - PROD_W){leaf_i[i][PROD_W-1]}}, leaf_i[i]};
      end else begin
        node[TREE_LEAVES + i] = '0;
      end
    end
    for (int n = 1; n < TREE_LEAVES; n++) begin
      sum_d[n] = node[2*n] + node[2*n + 1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      for (int n = 1; n < TREE_LEAVES; n++) begin
        sum_q[n] <= sum_d[n];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TREE_LEVELS; i++) begin
        tag_q[i] <= '0;
      end
    end else if (advance_i) begin
      tag_q[0] <= tag_i;
      for (int i = 1; i < TREE_LEVELS; i++) begin
        tag_q[i] <= tag_q[i-1];
      end
    end
  end

  assign sum_o = sum_q[1];
  assign tag_o = tag_q[TREE_LEVELS-1];

endmodule

FILE: src/valid_fir_convolver.sv
// ----------------------------------------------------------------------------
// valid_fir_convolver: valid-mode FIR convolution over framed sample streams
// Pipeline: the window, product and log2(MAX_TAPS) adder-tree registers lie
// between input transfer and result tvalid.
// Throughput: one sample per cycle; the pipeline stalls as a whole only when
// the output register holds a result that is not taken.
// Reset: asynchronous, active low; clears fill count, pipeline valids and the
// registers (coefficients zero, tap count 16). The sample chain needs no reset.
// ----------------------------------------------------------------------------
module valid_fir_convolver
  import vfc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration write port
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  // sample stream in
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [15:0]          s_axis_tdata,   // [15:0] sample
  input  logic [0:0]           s_axis_tuser,   // [0] frame_start
  input  logic                 s_axis_tlast,   // frame_end
  // result stream out
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [39:0]          m_axis_tdata,   // [35:0] conv_value, [39:36] zero
  output logic [0:0]           m_axis_tuser,   // [0] too_short
  output logic                 m_axis_tlast    // end_of_frame
);

  localparam int SEXT_SHIFT = SAMPLE_W - SAMPLE_BITS;

  // Pick tap t out of the packed coefficient words.
  function automatic logic signed [COEF_W-1:0] coef_of(
    input logic [COEF_WORDS-1:0][CFG_W-1:0] bank,
    input logic [3:0]                       t
  );
    logic [CFG_W-1:0] word;
    word = bank[t[3:2]];
    return word[t[1:0]*COEF_W +: COEF_W];
  endfunction

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [COEF_WORDS-1:0][CFG_W-1:0] coef_q;
  logic [TAP_CNT_W-1:0]             tap_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q      <= '0;
      tap_count_q <= TAP_CNT_W'(16);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_COEF_0:    coef_q[0]   <= cfg_data_i;
        REG_COEF_1:    coef_q[1]   <= cfg_data_i;
        REG_COEF_2:    coef_q[2]   <= cfg_data_i;
        REG_COEF_3:    coef_q[3]   <= cfg_data_i;
        REG_TAP_COUNT: tap_count_q <= cfg_data_i[TAP_CNT_W-1:0];
        default: begin
          // unmapped index: drop the write
        end
      endcase
    end
  end

  // Kernel length in use: zero counts as one, anything above MAX_TAPS clamps.
  logic [TAP_W-1:0] taps_k;

  always_comb begin
    if (tap_count_q == '0) begin
      taps_k = TAP_W'(1);
    end else if (tap_count_q > TAP_CNT_W'(MAX_TAPS)) begin
      taps_k = TAP_W'(MAX_TAPS);
    end else begin
      taps_k = tap_count_q[TAP_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Handshake: every stage moves together; the whole pipeline advances
  // whenever the output register is empty or being emptied.
  // --------------------------------------------------------------------------
  vfc_tag_t out_tag;
  logic     advance;
  logic     accept;

  assign advance       = !out_tag.valid || m_axis_tready;
  assign s_axis_tready = advance;
  assign accept        = s_axis_tvalid && advance;

  // --------------------------------------------------------------------------
  // Frame bookkeeping at the input transfer
  // --------------------------------------------------------------------------
  logic [TAP_W-1:0] fill_q;
  logic [TAP_W-1:0] fill_d;
  logic [TAP_W-1:0] fill_base;
  logic [TAP_W-1:0] fill_next;
  logic             enough;
  vfc_tag_t         in_tag;
  vfc_tag_t         win_tag_q;
  vfc_tag_t         prod_tag_q;

  always_comb begin
    // frame_start restarts the count with this sample
    fill_base = s_axis_tuser[0] ? '0 : fill_q;
    // saturate at the chain length
    fill_next = (fill_base < TAP_W'(MAX_TAPS)) ? fill_base + TAP_W'(1) : fill_base;
    enough    = (fill_next >= taps_k);
    // frame_end closes the frame after this sample
    fill_d    = s_axis_tlast ? '0 : fill_next;

    in_tag.valid     = accept && (enough || s_axis_tlast);
    in_tag.last      = s_axis_tlast;
    in_tag.too_short = !enough;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q     <= '0;
      win_tag_q  <= '0;
      prod_tag_q <= '0;
    end else begin
      if (accept) begin
        fill_q <= fill_d;
      end
      if (advance) begin
        win_tag_q  <= in_tag;
        prod_tag_q <= win_tag_q;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tap chain: cell 0 holds the newest sample, cell j the sample of age j.
  // Cell j is weighted by tap taps_k-1-j, so tap 0 meets the oldest sample
  // of the window.
  // --------------------------------------------------------------------------
  logic signed [SAMPLE_W-1:0] sample_in;
  logic [SAMPLE_W-1:0]        sample_shl;
  logic signed [SAMPLE_W-1:0] chain    [MAX_TAPS];
  logic signed [PROD_W-1:0]   products [MAX_TAPS];

  // use the low SAMPLE_BITS bits, sign extended
  assign sample_shl = s_axis_tdata[SAMPLE_W-1:0] << SEXT_SHIFT;
  assign sample_in  = $signed(sample_shl) >>> SEXT_SHIFT;

  for (genvar j = 0; j < MAX_TAPS; j++) begin : g_cell
    logic                       tap_en;
    logic [TAP_W-1:0]           tap_sel;
    logic signed [SAMPLE_W-1:0] feed;
    logic signed [COEF_W-1:0]   coef;

    assign tap_en  = (TAP_W'(j) < taps_k);
    assign tap_sel = taps_k - TAP_W'(j + 1);
    assign coef    = coef_of(coef_q, 4'(tap_sel[TAP_IDX_W-1:0]));

    if (j == 0) begin : g_head
      assign feed = sample_in;
    end else begin : g_link
      assign feed = chain[j-1];
    end

    vfc_cell u_cell (
      .clk_i     (clk_i),
      .shift_i   (accept),
      .advance_i (advance),
      .sample_i  (feed),
      .coef_i    (coef),
      .tap_en_i  (tap_en),
      .sample_o  (chain[j]),
      .product_o (products[j])
    );
  end

  // --------------------------------------------------------------------------
  // Reduction: the tree root is the output register
  // --------------------------------------------------------------------------
  logic signed [CONV_W-1:0] sum;

  vfc_add_tree u_tree (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .leaf_i    (products),
    .tag_i     (prod_tag_q),
    .sum_o     (sum),
    .tag_o     (out_tag)
  );

  // a short frame reports zero
  assign m_axis_tvalid = out_tag.valid;
  assign m_axis_tdata  = {4'b0, (out_tag.too_short ? CONV_W'(0) : sum)};
  assign m_axis_tuser  = out_tag.too_short;
  assign m_axis_tlast  = out_tag.last;

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the valid-mode FIR convolver
// Streams framed Q1.15 samples into the block and predicts every Q6.30 result,
// end-of-frame flag and short-frame flag. Each output transfer is compared with
// the oldest prediction. Directed frames cover full scale, short and one-sample
// frames and out-of-range tap counts. Random frames follow under three
// back-pressure patterns, with register changes between stretches of traffic.
// ----------------------------------------------------------------------------
module tb_top;
  import vfc_pkg::*;

  // pipeline depth of the block, used to let trailing no-result samples pass
  localparam int LAT_CYCLES = 2 + TREE_LEVELS;
  localparam int SEG_ITEMS  = 97;
  localparam int SEGS       = 6;
  localparam int MAX_REPORTS = 40;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_W-1:0]     cfg_data_i = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [15:0]          s_axis_tdata = '0;   // [15:0] sample
  logic [0:0]           s_axis_tuser = '0;   // [0] frame_start
  logic                 s_axis_tlast = 1'b0; // frame_end
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [39:0]          m_axis_tdata;        // [35:0] conv_value, [39:36] zero
  logic [0:0]           m_axis_tuser;        // [0] too_short
  logic                 m_axis_tlast;        // end_of_frame

  valid_fir_convolver dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #5000000;
    $display("CHECK FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Predictor state: shadow registers, tap delay line and frame fill count
  // --------------------------------------------------------------------------
  typedef struct {
    logic signed [CONV_W-1:0] conv;
    logic                     eof;
    logic                     short_frame;
  } conv_res_t;

  conv_res_t                 conv_q[$];      // predicted results, oldest first
  logic [CFG_W-1:0]          coef_reg [COEF_WORDS];
  logic [TAP_CNT_W-1:0]      taps_reg = TAP_CNT_W'(MAX_TAPS);
  logic signed [SAMPLE_W-1:0] delay_line [MAX_TAPS];
  int unsigned               fill_cnt = 0;
  int unsigned               frame_left = 0; // samples still planned in the open frame

  int unsigned src_idle_pct  = 7;
  int unsigned sink_idle_pct = 80;
  int unsigned err_cnt = 0;
  int unsigned n_samples = 0, n_results = 0, n_short = 0, n_eof = 0, n_cfg = 0;

  initial begin
    for (int i = 0; i < COEF_WORDS; i++) coef_reg[i] = '0;
    for (int i = 0; i < MAX_TAPS; i++) delay_line[i] = '0;
  end

  // kernel length actually used: zero acts as one, anything above the
  // maximum acts as the maximum
  function automatic int unsigned taps_in_use();
    if (taps_reg == 0) return 1;
    if (taps_reg > MAX_TAPS) return MAX_TAPS;
    return taps_reg;
  endfunction

  // Advance the shadow filter by one sample and queue the result it causes.
  function automatic void predict_conv(input logic signed [SAMPLE_W-1:0] x,
                                       input bit start, input bit last);
    int unsigned              k_len;
    logic signed [CONV_W-1:0] acc;
    logic signed [COEF_W-1:0] w;
    conv_res_t                r;
    k_len = taps_in_use();
    if (start) fill_cnt = 0;
    // newest sample sits at age 0
    for (int i = MAX_TAPS - 1; i > 0; i--) delay_line[i] = delay_line[i-1];
    delay_line[0] = x;
    if (fill_cnt < MAX_TAPS) fill_cnt++;
    if (fill_cnt >= k_len) begin
      acc = '0;
      // tap 0 meets the oldest sample of the window
      for (int k = 0; k < k_len; k++) begin
        w = coef_reg[k / 4][16 * (k % 4) +: 16];
        acc = acc + delay_line[k_len - 1 - k] * w;
      end
      r.conv = acc;
      r.eof = last;
      r.short_frame = 1'b0;
      conv_q.push_back(r);
    end else if (last) begin
      r.conv = '0;
      r.eof = 1'b1;
      r.short_frame = 1'b1;
      conv_q.push_back(r);
    end
    if (last) fill_cnt = 0;
  endfunction

  // --------------------------------------------------------------------------
  // Result checking: compare every output transfer against the oldest entry
  // --------------------------------------------------------------------------
  function automatic void report_mismatch(input string field, input longint exp_v,
                                          input longint act_v);
    err_cnt++;
    if (err_cnt <= MAX_REPORTS)
      $error("%s mismatch: expected %0d, got %0d", field, exp_v, act_v);
  endfunction

  function automatic void check_result();
    conv_res_t exp_r;
    longint    act_conv;
    act_conv = longint'($signed(m_axis_tdata[CONV_W-1:0]));
    if (conv_q.size() == 0) begin
      err_cnt++;
      if (err_cnt <= MAX_REPORTS)
        $error("result with no prediction waiting: conv_value %0d", act_conv);
      return;
    end
    exp_r = conv_q.pop_front();
    n_results++;
    if (exp_r.short_frame) n_short++;
    if (exp_r.eof) n_eof++;
    if (m_axis_tdata[CONV_W-1:0] !== exp_r.conv)
      report_mismatch("conv_value", longint'(exp_r.conv), act_conv);
    if (m_axis_tlast !== exp_r.eof)
      report_mismatch("end_of_frame", exp_r.eof, m_axis_tlast);
    if (m_axis_tuser[0] !== exp_r.short_frame)
      report_mismatch("too_short", exp_r.short_frame, m_axis_tuser[0]);
    if (m_axis_tdata[39:CONV_W] !== '0)
      report_mismatch("tdata padding", 0, m_axis_tdata[39:CONV_W]);
  endfunction

  // Sample the output side on the edge, then pick the next ready level.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) check_result();
    m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  // Offer one sample; return at the edge of its transfer with tvalid still
  // high, so the next call either replaces the data or drops tvalid.
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] x,
                             input bit start, input bit last);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= x;
    s_axis_tuser  <= start;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_conv(x, start, last);
    n_samples++;
  endtask

  // Drop the input valid and wait until every predicted result has come out.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (conv_q.size() != 0);
  endtask

  // Drain, then let samples that cause no result leave the pipeline before
  // touching any register.
  task automatic settle();
    wait_drained();
    repeat (2 * LAT_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    if (idx == REG_TAP_COUNT) taps_reg = data[TAP_CNT_W-1:0];
    else coef_reg[idx] = data;
    n_cfg++;
  endtask

  // full-scale words now and then, otherwise fully random
  function automatic logic [CFG_W-1:0] pick_coef_word();
    case ($urandom_range(9))
      0: return {4{16'h8000}};
      1: return {4{16'h7FFF}};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(9))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      default: return SAMPLE_W'($urandom_range(65535));
    endcase
  endfunction

  task automatic randomize_registers();
    logic [CFG_W-1:0] tap_word;
    int unsigned      pick;
    write_reg(REG_COEF_0, pick_coef_word());
    write_reg(REG_COEF_1, pick_coef_word());
    write_reg(REG_COEF_2, pick_coef_word());
    write_reg(REG_COEF_3, pick_coef_word());
    // junk in the upper bits must be ignored; mostly legal lengths
    tap_word = {$urandom, $urandom};
    pick = $urandom_range(9);
    if (pick == 0) tap_word[TAP_CNT_W-1:0] = '0;
    else if (pick == 1) tap_word[TAP_CNT_W-1:0] = TAP_CNT_W'($urandom_range(17, 31));
    else tap_word[TAP_CNT_W-1:0] = TAP_CNT_W'($urandom_range(1, MAX_TAPS));
    write_reg(REG_TAP_COUNT, tap_word);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Reset tap count of 16, every coefficient -1.0, every sample -1.0: the
  // largest possible sum, with fifteen silent samples before it.
  task automatic test_full_scale();
    write_reg(REG_COEF_0, {4{16'h8000}});
    write_reg(REG_COEF_1, {4{16'h8000}});
    write_reg(REG_COEF_2, {4{16'h8000}});
    write_reg(REG_COEF_3, {4{16'h8000}});
    for (int i = 0; i < MAX_TAPS; i++)
      send_sample(16'sh8000, i == 0, i == MAX_TAPS - 1);
  endtask

  // One-sample frame and a frame opened without a start flag, both shorter
  // than the kernel.
  task automatic test_short_frames();
    settle();
    write_reg(REG_TAP_COUNT, 64'd3);
    send_sample(16'sh1234, 1'b1, 1'b1);
    send_sample(-16'sd5, 1'b0, 1'b0);
    send_sample(16'sd7, 1'b0, 1'b1);
  endtask

  // Tap count of zero acts as one, all ones acts as the maximum, one is one.
  task automatic test_tap_limits();
    settle();
    write_reg(REG_COEF_0, {16'h0001, 16'h8000, 16'h8000, 16'h7FFF});
    write_reg(REG_TAP_COUNT, 64'd0);
    send_sample(16'sh7FFF, 1'b1, 1'b1);
    settle();
    write_reg(REG_TAP_COUNT, '1);
    send_sample(-16'sd1, 1'b1, 1'b1);
    settle();
    write_reg(REG_TAP_COUNT, 64'd1);
    send_sample(16'sh8000, 1'b1, 1'b1);
  endtask

  // Mostly well-formed frames around the kernel length with random content;
  // some short, some long, some with missing or stray flags. Registers change
  // between stretches, often in the middle of an open frame.
  task automatic test_random_stream(input int unsigned src_pct, input int unsigned sink_pct);
    int unsigned roll;
    bit          start_f, last_f;
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    for (int s = 0; s < SEGS; s++) begin
      settle();
      randomize_registers();
      for (int n = 0; n < SEG_ITEMS; n++) begin
        // pause the source once per pattern until the output side catches up
        if (s == 1 && n == SEG_ITEMS / 2) wait_drained();
        if (frame_left == 0) begin
          roll = $urandom_range(99);
          if (roll < 12) frame_left = $urandom_range(1, taps_in_use());
          else if (roll < 17) frame_left = $urandom_range(40, 70);
          else frame_left = taps_in_use() + $urandom_range(0, 10);
          start_f = ($urandom_range(99) >= 8);
        end else begin
          start_f = ($urandom_range(99) < 3);
        end
        if (frame_left == 1) last_f = ($urandom_range(99) >= 5);
        else last_f = ($urandom_range(99) < 2);
        if (last_f) frame_left = 0;
        else frame_left--;
        send_sample(pick_sample(), start_f, last_f);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_full_scale();
    test_short_frames();
    test_tap_limits();
    // source nearly always ready, sink often stalled; then the reverse;
    // then full rate on both sides
    test_random_stream(7, 80);
    test_random_stream(80, 7);
    test_random_stream(0, 0);

    // collect what is still in flight, bounded, then watch for strays
    s_axis_tvalid <= 1'b0;
    for (int c = 0; c < 20000 && conv_q.size() != 0; c++) @(posedge clk_i);
    repeat (2 * LAT_CYCLES) @(posedge clk_i);
    if (conv_q.size() != 0) begin
      err_cnt++;
      $error("%0d predicted results never arrived", conv_q.size());
    end

    $display("Run covered %0d samples and %0d register writes; %0d results checked,",
             n_samples, n_cfg, n_results);
    $display("%0d of them closing a frame and %0d flagged as short frames.", n_eof, n_short);
    if (err_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
